### rtl/core/word_stream_hash64_to32_core_assert.svh
// ----------------------------------------------------------------------------
// word_stream_hash64_to32_core_assert
// Assertion macros for the word stream hash core.
// They expect signals named clk and rst in the scope of use.
// ----------------------------------------------------------------------------
`ifndef WORD_STREAM_HASH64_TO32_CORE_ASSERT_SVH
`define WORD_STREAM_HASH64_TO32_CORE_ASSERT_SVH

// Same-cycle implication.
`define WSH_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/wsh_pkg.sv
// ----------------------------------------------------------------------------
// wsh_pkg
// Types, constants and helpers shared by the word stream hash core.
// ----------------------------------------------------------------------------
package wsh_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [63:0] MIX_C1   = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] MIX_C2   = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] STEP_ADD = 64'h0000_0000_52dc_e729;
  localparam logic [63:0] FIN_M1   = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FIN_M2   = 64'hc4ce_b9fe_1a85_ec53;

  // 64x64 low product takes four passes through the 32x32 multiplier
  localparam logic [1:0] MUL_LAST_STEP = 2'd3;

  typedef struct packed {
    logic [63:0] key_word;
    logic        has_word;
    logic [31:0] start_hash;
    logic        first_item;
    logic        last_item;
  } q_entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_C1,
    BK_MUL_C2,
    BK_STEP,
    BK_FIN_START,
    BK_FIN_M1,
    BK_FIN_M2
  } back_state_t;

  function automatic logic [63:0] rotl31(input logic [63:0] x);
    return {x[32:0], x[63:33]};
  endfunction

  function automatic logic [63:0] rotl27(input logic [63:0] x);
    return {x[36:0], x[63:37]};
  endfunction

  function automatic logic [63:0] fold33(input logic [63:0] x);
    return x ^ {33'd0, x[63:33]};
  endfunction

endpackage

### rtl/core/wsh_ifs.sv
// ----------------------------------------------------------------------------
// wsh_ifs
// Valid/ready channels for key words in and hash values out.
// ----------------------------------------------------------------------------
interface wsh_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_word;
  logic        has_word;
  logic [31:0] key_length;
  logic        first_item;
  logic        last_item;

  modport source(output valid, key_word, has_word, key_length, first_item, last_item,
                 input ready);
  modport sink(input valid, key_word, has_word, key_length, first_item, last_item,
               output ready);
endinterface

interface wsh_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest;

  modport source(output valid, digest, input ready);
  modport sink(input valid, digest, output ready);
endinterface

### rtl/core/wsh_front.sv
// ----------------------------------------------------------------------------
// wsh_front
// Accepts key items, holds the seed and precomputes the start value.
// ----------------------------------------------------------------------------
module wsh_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  wsh_key_if.sink            key_in,
  input  logic               q_full,
  output logic               q_push,
  output wsh_pkg::q_entry_t  q_entry
);

  logic [31:0] hash_seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= '0;
    end else if (cfg_wr_en) begin
      hash_seed <= cfg_wr_data;
    end
  end

  assign key_in.ready = !q_full;
  assign q_push       = key_in.valid && !q_full;

  always_comb begin
    q_entry.key_word   = key_in.key_word;
    q_entry.has_word   = key_in.has_word;
    q_entry.start_hash = hash_seed ^ key_in.key_length;
    q_entry.first_item = key_in.first_item;
    q_entry.last_item  = key_in.last_item;
  end

endmodule

### rtl/core/wsh_queue.sv
// ----------------------------------------------------------------------------
// wsh_queue
// Small register FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module wsh_queue #(
  parameter int DEPTH = wsh_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wsh_pkg::q_entry_t  push_entry,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output wsh_pkg::q_entry_t  head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wsh_pkg::q_entry_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

### rtl/core/wsh_mul.sv
// ----------------------------------------------------------------------------
// wsh_mul
// Low 64 bits of a 64x64 product from one 32x32 multiplier.
// ----------------------------------------------------------------------------
module wsh_mul (
  input  logic               clk,
  input  logic               rst,
  input  wsh_pkg::mul_req_t  req,
  output logic               busy,
  output logic [63:0]        product
);

  logic [63:0] op_a;
  logic [63:0] op_b;
  logic [1:0]  step;
  logic [63:0] part;
  logic [63:0] acc;
  logic [31:0] mx;
  logic [31:0] my;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == wsh_pkg::MUL_LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  // lo*lo, lo*hi, hi*lo; the cross terms only feed the upper half
  always_comb begin
    unique case (step)
      2'd1: begin
        mx = op_a[31:0];
        my = op_b[63:32];
      end
      2'd2: begin
        mx = op_a[63:32];
        my = op_b[31:0];
      end
      default: begin
        mx = op_a[31:0];
        my = op_b[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_a <= req.a;
      op_b <= req.b;
    end
    if (busy) begin
      part <= mx * my;
      unique case (step)
        2'd0: acc <= acc;
        2'd1: acc <= part;
        default: acc[63:32] <= acc[63:32] + part[31:0];
      endcase
    end
  end

  assign product = acc;

endmodule

### rtl/core/wsh_back.sv
// ----------------------------------------------------------------------------
// wsh_back
// Sequencer that mixes queued words into the running hash and finalizes.
// ----------------------------------------------------------------------------
module wsh_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  wsh_pkg::q_entry_t  q_head,
  output logic               q_pop,
  output wsh_pkg::mul_req_t  mul_req,
  input  logic               mul_busy,
  input  logic [63:0]        mul_product,
  wsh_hash_if.source         hash_out
);

  wsh_pkg::back_state_t state, state_next;
  logic [63:0] hash, hash_next;
  logic [63:0] tmp, tmp_next;
  logic        last_flag, last_flag_next;
  logic        res_valid, res_valid_next;
  logic [31:0] res_value, res_value_next;
  logic [63:0] h0;
  logic        out_free;

  assign out_free = !res_valid || hash_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wsh_pkg::BK_IDLE;
      hash      <= '0;
      last_flag <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      hash      <= hash_next;
      last_flag <= last_flag_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    tmp       <= tmp_next;
    res_value <= res_value_next;
  end

  assign hash_out.valid  = res_valid;
  assign hash_out.digest = res_value;

  always_comb begin
    state_next     = state;
    hash_next      = hash;
    tmp_next       = tmp;
    last_flag_next = last_flag;
    res_value_next = res_value;
    res_valid_next = res_valid && !hash_out.ready;
    q_pop          = 1'b0;
    mul_req        = '0;
    h0             = q_head.first_item ? {32'd0, q_head.start_hash} : hash;

    unique case (state)
      wsh_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          hash_next      = h0;
          last_flag_next = q_head.last_item;
          if (q_head.has_word) begin
            mul_req.start = 1'b1;
            mul_req.a     = q_head.key_word;
            mul_req.b     = wsh_pkg::MIX_C1;
            state_next    = wsh_pkg::BK_MUL_C1;
          end else if (q_head.last_item) begin
            state_next = wsh_pkg::BK_FIN_START;
          end
        end
      end
      wsh_pkg::BK_MUL_C1: begin
        if (!mul_busy) begin
          mul_req.start = 1'b1;
          mul_req.a     = wsh_pkg::rotl31(mul_product);
          mul_req.b     = wsh_pkg::MIX_C2;
          state_next    = wsh_pkg::BK_MUL_C2;
        end
      end
      wsh_pkg::BK_MUL_C2: begin
        if (!mul_busy) begin
          tmp_next   = wsh_pkg::rotl27(hash ^ mul_product);
          state_next = wsh_pkg::BK_STEP;
        end
      end
      wsh_pkg::BK_STEP: begin
        // h * 5 as shift-add
        hash_next  = {tmp[61:0], 2'b00} + tmp + wsh_pkg::STEP_ADD;
        state_next = last_flag ? wsh_pkg::BK_FIN_START : wsh_pkg::BK_IDLE;
      end
      wsh_pkg::BK_FIN_START: begin
        mul_req.start = 1'b1;
        mul_req.a     = wsh_pkg::fold33(hash);
        mul_req.b     = wsh_pkg::FIN_M1;
        state_next    = wsh_pkg::BK_FIN_M1;
      end
      wsh_pkg::BK_FIN_M1: begin
        if (!mul_busy) begin
          mul_req.start = 1'b1;
          mul_req.a     = wsh_pkg::fold33(mul_product);
          mul_req.b     = wsh_pkg::FIN_M2;
          state_next    = wsh_pkg::BK_FIN_M2;
        end
      end
      wsh_pkg::BK_FIN_M2: begin
        if (!mul_busy && out_free) begin
          res_value_next = 32'(wsh_pkg::fold33(mul_product));
          res_valid_next = 1'b1;
          state_next     = wsh_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = wsh_pkg::BK_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/word_stream_hash64_to32_core.sv
// Back end: an item with a word is mixed by two multiplies (MIX_C1, MIX_C2)
// and a step; a last item adds two finalization multiplies (FIN_M1, FIN_M2);
// an empty non-last item is only popped. The back end uses the shared 32x32
// multiplier and finishes one item before it pops the next.
// The input queue keeps accepting, until full, while the back end works or output stalls.
// Reset (synchronous, active high) clears seed, running hash and the queue.
`include "word_stream_hash64_to32_core_assert.svh"
// ----------------------------------------------------------------------------
// word_stream_hash64_to32_core
// Streaming 64-bit word hash with a 32-bit finalized result.
// ----------------------------------------------------------------------------
module word_stream_hash64_to32_core #(
  parameter int QUEUE_DEPTH = wsh_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  wsh_key_if.sink     key_in,
  wsh_hash_if.source  hash_out
);

  wsh_pkg::q_entry_t push_entry;
  wsh_pkg::q_entry_t q_head;
  wsh_pkg::mul_req_t mul_req;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  logic              mul_busy;
  logic [63:0]       mul_product;

  wsh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .key_in      (key_in),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (push_entry)
  );

  wsh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  wsh_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .busy    (mul_busy),
    .product (mul_product)
  );

  wsh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .mul_req     (mul_req),
    .mul_busy    (mul_busy),
    .mul_product (mul_product),
    .hash_out    (hash_out)
  );

  `WSH_ASSERT_IMPLIES(a_mul_start_idle, mul_req.start, !mul_busy, "multiply issued while busy")
  `WSH_ASSERT_NEXT(a_mul_launch, mul_req.start, mul_busy, "multiply did not launch")
  `WSH_ASSERT_IMPLIES(a_mul_length, $fell(mul_busy), $past(mul_busy, 4), "multiply too short")
  `WSH_ASSERT_IMPLIES(a_pop_nonempty, q_pop, q_valid, "pop from empty queue")

endmodule
